// ===== hdl/bbw_pkg.sv =====
// Package for the bracket branch weigher: symbol codes, widths and the
// stack control struct. No dependencies.
package bbw_pkg;

  localparam int WEIGHT_W        = 16;
  localparam int TOTAL_W         = 32;
  localparam int CODE_W          = 8;
  localparam int STACK_DEPTH_DEF = 64;

  localparam logic [CODE_W-1:0] CODE_STEM  = 8'd0;
  localparam logic [CODE_W-1:0] CODE_OPEN  = 8'd8;
  localparam logic [CODE_W-1:0] CODE_CLOSE = 8'd9;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_op_t;

endpackage

// ===== hdl/bbw_cell.sv =====
// One entry of the shift stack: takes the entry above on push, the entry
// below on pop, otherwise holds. Depends on bbw_pkg.
module bbw_cell
  import bbw_pkg::*;
(
  input  logic                clk,
  input  stack_op_t           op,
  input  logic [WEIGHT_W-1:0] from_above,
  input  logic [WEIGHT_W-1:0] from_below,
  output logic [WEIGHT_W-1:0] entry
);

  always_ff @(posedge clk) begin
    if (op.push) begin
      entry <= from_above;
    end else if (op.pop) begin
      entry <= from_below;
    end
  end

endmodule

// ===== hdl/bbw_stack.sv =====
// Row of bbw_cell entries forming a shift stack with the top in cell 0.
// Depends on bbw_pkg and bbw_cell.
module bbw_stack
  import bbw_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  stack_op_t           op,
  input  logic [WEIGHT_W-1:0] push_data,
  output logic [WEIGHT_W-1:0] top
);

  logic [WEIGHT_W-1:0] entries [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [WEIGHT_W-1:0] above;
    logic [WEIGHT_W-1:0] below;

    if (i == 0) begin : g_first
      assign above = push_data;
    end else begin : g_mid
      assign above = entries[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner
      assign below = entries[i+1];
    end

    bbw_cell u_cell (
      .clk        (clk),
      .op         (op),
      .from_above (above),
      .from_below (below),
      .entry      (entries[i])
    );
  end

  assign top = entries[0];

endmodule

// ===== hdl/bracket_branch_weigher.sv =====
// Top level of the bracket branch weigher: symbol decode, running weight,
// total sum and a two-deep output buffer. Depends on bbw_pkg and bbw_stack.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  input   | in_valid, in_ready, symbol_code, last_symbol | into block
//  output  | out_valid, out_ready, element_weight,        | out of block
//          | total_weight, done_res                       |
//
// Each symbol is decoded and its stack push or pop done in the cycle it is
// accepted; its result is registered in the main or, on a stall, the skid
// register. One transaction per cycle is sustained while in_ready is high;
// the combinational update of the running weight against the top stack
// cell sets that figure. The output side has a main and a skid register, so
// one more symbol is accepted after the output stalls; in_ready drops only
// when the skid register is occupied.
// Synchronous reset clears the running weight, count, total, skip flag and
// both output valids; stack cells are not reset.
module bracket_branch_weigher
  import bbw_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CODE_W-1:0]   symbol_code,
  input  logic                last_symbol,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [WEIGHT_W-1:0] element_weight,
  output logic [TOTAL_W-1:0]  total_weight,
  output logic                done_res
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [WEIGHT_W-1:0] W16_MAX = '1;
  localparam logic [TOTAL_W-1:0]  W32_MAX = '1;

  // String state
  logic [WEIGHT_W-1:0] running_weight, running_weight_next;
  logic [CNT_W-1:0]    stack_count, stack_count_next;
  logic [TOTAL_W-1:0]  total_sum, total_sum_next;
  logic                skip_next, skip_next_next;

  // Output buffer: main and skid registers
  logic                skid_valid;
  logic [WEIGHT_W-1:0] skid_elem;
  logic [TOTAL_W-1:0]  skid_total;
  logic                skid_done;

  logic                in_fire;
  logic [WEIGHT_W-1:0] stack_top;
  stack_op_t           stack_op;
  logic [WEIGHT_W-1:0] elem;
  logic [TOTAL_W-1:0]  res_total;
  logic                stack_full;
  logic                stack_empty;
  logic [WEIGHT_W:0]   add_one;
  logic [WEIGHT_W:0]   add_two;
  logic [WEIGHT_W:0]   add_pop;
  logic [TOTAL_W:0]    sum_wide;

  assign in_ready    = !skid_valid;
  assign in_fire     = in_valid && in_ready;
  assign stack_full  = (stack_count == CNT_W'(STACK_DEPTH));
  assign stack_empty = (stack_count == '0);

  assign add_one = {1'b0, running_weight} + (WEIGHT_W+1)'(1);
  assign add_two = {1'b0, running_weight} + (WEIGHT_W+1)'(2);
  assign add_pop = {1'b0, running_weight} + {1'b0, stack_top};

  // Decode one symbol; a pending skip swallows it whatever its code
  always_comb begin
    running_weight_next = running_weight;
    stack_count_next    = stack_count;
    skip_next_next      = skip_next;
    elem                = '0;
    stack_op            = '0;
    if (skip_next) begin
      skip_next_next = 1'b0;
    end else begin
      unique case (symbol_code)
        CODE_STEM: begin
          running_weight_next = add_one[WEIGHT_W] ? W16_MAX : add_one[WEIGHT_W-1:0];
          elem                = running_weight_next;
        end
        CODE_CLOSE: begin
          elem = WEIGHT_W'(1);
          if (stack_full) begin
            // Recursion guard: no push, bump by two and drop the next symbol
            running_weight_next = add_two[WEIGHT_W] ? W16_MAX : add_two[WEIGHT_W-1:0];
            skip_next_next      = 1'b1;
          end else begin
            stack_op.push       = 1'b1;
            stack_count_next    = stack_count + CNT_W'(1);
            running_weight_next = WEIGHT_W'(1);
          end
        end
        CODE_OPEN: begin
          if (!stack_empty) begin
            stack_op.pop        = 1'b1;
            stack_count_next    = stack_count - CNT_W'(1);
            running_weight_next = add_pop[WEIGHT_W] ? W16_MAX : add_pop[WEIGHT_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
    sum_wide       = {1'b0, total_sum} + (TOTAL_W+1)'(elem);
    total_sum_next = sum_wide[TOTAL_W] ? W32_MAX : sum_wide[TOTAL_W-1:0];
    res_total      = last_symbol ? total_sum_next : '0;
  end

  bbw_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk       (clk),
    .op        (in_fire ? stack_op : stack_op_t'('0)),
    .push_data (running_weight),
    .top       (stack_top)
  );

  // Advance string state on each accepted transaction; clear after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      running_weight <= '0;
      stack_count    <= '0;
      total_sum      <= '0;
      skip_next      <= 1'b0;
    end else if (in_fire) begin
      if (last_symbol) begin
        running_weight <= '0;
        stack_count    <= '0;
        total_sum      <= '0;
        skip_next      <= 1'b0;
      end else begin
        running_weight <= running_weight_next;
        stack_count    <= stack_count_next;
        total_sum      <= total_sum_next;
        skip_next      <= skip_next_next;
      end
    end
  end

  // Output register with skid: refill main from skid first, park in skid on stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        element_weight <= skid_elem;
        total_weight   <= skid_total;
        done_res       <= skid_done;
      end else if (in_fire) begin
        element_weight <= elem;
        total_weight   <= res_total;
        done_res       <= last_symbol;
      end
    end else if (in_fire) begin
      skid_elem  <= elem;
      skid_total <= res_total;
      skid_done  <= last_symbol;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_skid_implies_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds data while main register is empty");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_symbol |=> stack_count == '0 && total_sum == '0 && !skip_next)
    else $error("string state not cleared after last symbol");

  a_skip_one_shot: assert property (@(posedge clk) disable iff (rst)
    in_fire && skip_next |=> !skip_next)
    else $error("skip flag survived a skipped symbol");
`endif

endmodule
